// File: rtl/core/zcd_pkg.sv
// zcd_pkg: shared widths, register indexes and control bundles of the
// zero crossing detector. Used by zcd_ctrl, zcd_dpath and the top level.
`default_nettype none

package zcd_pkg;

   // field widths
   localparam int SAMPLE_BITS = 16;
   localparam int INDEX_BITS  = 32;
   localparam int FRAC_BITS   = 16;

   // configuration port
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 1;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_DETECT_RISING  = 2'd0,
      CSR_DETECT_FALLING = 2'd1
   } zcd_csr_index_type;

   // restoring divider: one quotient bit per step, fraction plus the integer bit
   localparam int DIV_STEPS = FRAC_BITS + 1;
   localparam int STEP_BITS = $clog2(DIV_STEPS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(DIV_STEPS - 1);

   // controller to datapath
   typedef struct packed {
      logic load;      // item accepted: capture operands, advance signal state
      logic div_step;  // one divider iteration
      logic rsp_load;  // copy finished result into the output register
   } zcd_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic emit;      // accepted item gives an enabled crossing
   } zcd_status_type;

endpackage

`default_nettype wire

// File: rtl/core/zcd_ctrl.sv
// zcd_ctrl: sequencer of the zero crossing detector.
// Depends on zcd_pkg for the command and status bundles.
`default_nettype none

module zcd_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_stall,
   output logic                     rsp_valid,
   input  wire logic                rsp_stall,
   input  wire zcd_pkg::zcd_status_type status,
   output zcd_pkg::zcd_cmd_type     cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_DELIVER
   } state_type;

   state_type                        state_ff, state_in;
   logic [zcd_pkg::STEP_BITS-1:0]    step_ff, step_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             accept;
   logic                             rsp_free;

   // handshake terms
   assign req_stall = (state_ff != ST_IDLE);
   assign accept    = req_valid && (state_ff == ST_IDLE);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.rsp_load = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load = 1'b1;
               step_in  = '0;
               if (status.emit) begin
                  state_in = ST_DIVIDE;
               end
            end
         end
         ST_DIVIDE: begin
            cmd.div_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == zcd_pkg::STEP_LAST) begin
               state_in = ST_DELIVER;
            end
         end
         ST_DELIVER: begin
            if (rsp_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output valid: set on load, cleared when taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

// File: rtl/core/zcd_dpath.sv
// zcd_dpath: signal state, crossing test, restoring divider and result register.
// Depends on zcd_pkg for widths, register indexes and control bundles.
`default_nettype none

module zcd_dpath (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic signed [zcd_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                req_last_sample,
   input  wire logic                                csr_write,
   input  wire logic [zcd_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [zcd_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire zcd_pkg::zcd_cmd_type                cmd,
   output zcd_pkg::zcd_status_type                  status,
   output logic [zcd_pkg::INDEX_BITS-1:0]           rsp_crossing_index,
   output logic [zcd_pkg::FRAC_BITS:0]              rsp_crossing_fraction,
   output logic                                     rsp_falling
);

   localparam int SB = zcd_pkg::SAMPLE_BITS;
   localparam int IB = zcd_pkg::INDEX_BITS;
   localparam int FB = zcd_pkg::FRAC_BITS;

   // configuration
   logic          detect_rising_ff, detect_falling_ff;

   // signal state
   logic [SB-1:0] prev_ff, prev_in;
   logic          have_ff, have_in;
   logic [IB-1:0] count_ff, count_in;

   // divider operands and work registers
   logic [SB:0]   rem_ff, rem_in;
   logic [SB-1:0] den_ff, den_in;
   logic [FB:0]   quo_ff, quo_in;
   logic [IB-1:0] index_ff, index_in;
   logic          fall_ff, fall_in;

   // result register
   logic [IB-1:0] rsp_index_ff;
   logic [FB:0]   rsp_frac_ff;
   logic          rsp_fall_ff;

   // crossing test terms
   logic          prev_neg, cur_neg;
   logic [SB-1:0] prev_mag, cur_mag;
   logic [SB:0]   mag_sum;
   logic          is_rising, is_falling;

   // divider step terms
   logic [SB:0]   diff;
   logic          qbit;
   logic [SB:0]   kept;

   // magnitudes of previous and current samples, and the crossing test
   always_comb begin
      prev_neg   = prev_ff[SB-1];
      cur_neg    = req_sample[SB-1];
      prev_mag   = prev_neg ? (~prev_ff + 1'b1) : prev_ff;
      cur_mag    = cur_neg ? (~req_sample + 1'b1) : req_sample;
      mag_sum    = {1'b0, prev_mag} + {1'b0, cur_mag};
      is_rising  = have_ff && prev_neg && !cur_neg;
      is_falling = have_ff && !prev_neg && cur_neg;
      status.emit = (is_rising && detect_rising_ff) || (is_falling && detect_falling_ff);
   end

   // signal state update on each accepted item
   always_comb begin
      prev_in  = prev_ff;
      have_in  = have_ff;
      count_in = count_ff;
      if (cmd.load) begin
         if (req_last_sample) begin
            prev_in  = '0;
            have_in  = 1'b0;
            count_in = '0;
         end else begin
            prev_in  = req_sample;
            have_in  = 1'b1;
            count_in = count_ff + 1'b1;
         end
      end
   end

   // one restoring step: remainder stays below the divisor, then shifts up
   always_comb begin
      diff = rem_ff - {1'b0, den_ff};
      qbit = (rem_ff >= {1'b0, den_ff});
      kept = qbit ? diff : rem_ff;
   end

   // divider registers
   always_comb begin
      rem_in   = rem_ff;
      den_in   = den_ff;
      quo_in   = quo_ff;
      index_in = index_ff;
      fall_in  = fall_ff;
      if (cmd.load) begin
         rem_in   = {1'b0, prev_mag};
         den_in   = mag_sum[SB-1:0];
         quo_in   = '0;
         index_in = count_ff - 1'b1;
         fall_in  = is_falling;
      end else if (cmd.div_step) begin
         rem_in = {kept[SB-1:0], 1'b0};
         quo_in = {quo_ff[FB-1:0], qbit};
      end
   end

   // control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         detect_rising_ff  <= 1'b1;
         detect_falling_ff <= 1'b1;
         prev_ff           <= '0;
         have_ff           <= 1'b0;
         count_ff          <= '0;
      end else begin
         if (csr_write) begin
            case (csr_index)
               zcd_pkg::CSR_DETECT_RISING:  detect_rising_ff  <= csr_data[0];
               zcd_pkg::CSR_DETECT_FALLING: detect_falling_ff <= csr_data[0];
               default: begin
               end
            endcase
         end
         prev_ff  <= prev_in;
         have_ff  <= have_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      rem_ff   <= rem_in;
      den_ff   <= den_in;
      quo_ff   <= quo_in;
      index_ff <= index_in;
      fall_ff  <= fall_in;
      if (cmd.rsp_load) begin
         rsp_index_ff <= index_ff;
         rsp_frac_ff  <= quo_ff;
         rsp_fall_ff  <= fall_ff;
      end
   end

   assign rsp_crossing_index    = rsp_index_ff;
   assign rsp_crossing_fraction = rsp_frac_ff;
   assign rsp_falling           = rsp_fall_ff;

endmodule

`default_nettype wire

// File: rtl/core/zero_crossing_detector.sv
// zero_crossing_detector: top level, joins sequencer and datapath.
// Depends on zcd_pkg, zcd_ctrl and zcd_dpath.
//
// Usage:
//   req_* carries one signed sample and a last-sample flag per item; an item
//   is taken when req_valid is high and req_stall is low. rsp_* carries one
//   crossing: index of the sample before it, Q1.16 fraction (65536 = 1.0)
//   and direction. csr_write with csr_index selects detect_rising (0) or
//   detect_falling (1); write only while the block is idle.
// Timing:
//   an item with no reported crossing is done when accepted. An item with a
//   crossing passes capture, 17 restoring-divider steps (one quotient bit
//   each) and the load of the output register, which then shows rsp_valid.
//   The divider is the only iterative unit. req_stall is high while the
//   divider runs or a result waits to be loaded.
// Reset:
//   synchronous; both crossing kinds enabled, no previous sample, index 0.
// Stalls:
//   a result held by rsp_stall stays in the output register; the next item
//   is accepted meanwhile and its result waits in the divider until the
//   register frees up.
`default_nettype none

module zero_crossing_detector (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_stall,
   input  wire logic signed [zcd_pkg::SAMPLE_BITS-1:0] req_sample,
   input  wire logic                                   req_last_sample,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_stall,
   output logic [zcd_pkg::INDEX_BITS-1:0]              rsp_crossing_index,
   output logic [zcd_pkg::FRAC_BITS:0]                 rsp_crossing_fraction,
   output logic                                        rsp_falling,
   input  wire logic                                   csr_write,
   input  wire logic [zcd_pkg::CSR_INDEX_BITS-1:0]     csr_index,
   input  wire logic [zcd_pkg::CSR_DATA_BITS-1:0]      csr_data
);

   zcd_pkg::zcd_cmd_type    cmd;
   zcd_pkg::zcd_status_type status;

   // sequencer
   zcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath
   zcd_dpath u_dpath (
      .clock                 (clock),
      .reset                 (reset),
      .req_sample            (req_sample),
      .req_last_sample       (req_last_sample),
      .csr_write             (csr_write),
      .csr_index             (csr_index),
      .csr_data              (csr_data),
      .cmd                   (cmd),
      .status                (status),
      .rsp_crossing_index    (rsp_crossing_index),
      .rsp_crossing_fraction (rsp_crossing_fraction),
      .rsp_falling           (rsp_falling)
   );

endmodule

`default_nettype wire
